// ===== hw/rtl/wmre_pkg.sv =====
// Package: shared types and constants for the word mangling rule engine.
package wmre_pkg;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_RULE   = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_Z  = 8'h7A;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CASE_BIT  = 8'h20;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam logic [7:0] R_LOWER   = 8'h6C; // l
	localparam logic [7:0] R_UPPER   = 8'h75; // u
	localparam logic [7:0] R_TOGGLE  = 8'h74; // t
	localparam logic [7:0] R_CAP     = 8'h63; // c
	localparam logic [7:0] R_UNCAP   = 8'h43; // C
	localparam logic [7:0] R_TOG_AT  = 8'h54; // T
	localparam logic [7:0] R_OVER    = 8'h6F; // o
	localparam logic [7:0] R_TRUNC   = 8'h27; // '
	localparam logic [7:0] R_DEL_LST = 8'h5D; // ]
	localparam logic [7:0] R_SUBST   = 8'h73; // s
	localparam logic [7:0] R_REVERSE = 8'h72; // r
	localparam logic [7:0] R_DUP     = 8'h64; // d
	localparam logic [7:0] R_MIRROR  = 8'h66; // f
	localparam logic [7:0] R_ROT_L   = 8'h7B; // {
	localparam logic [7:0] R_ROT_R   = 8'h7D; // }
	localparam logic [7:0] R_APPEND  = 8'h24; // $
	localparam logic [7:0] R_PREPEND = 8'h5E; // ^
	localparam logic [7:0] R_DEL_FST = 8'h5B; // [
	localparam logic [7:0] R_DEL_AT  = 8'h44; // D
	localparam logic [7:0] R_EXTRACT = 8'h78; // x
	localparam logic [7:0] R_INSERT  = 8'h69; // i
	localparam logic [7:0] R_PURGE   = 8'h40; // @
	localparam logic [7:0] R_DUP_FST = 8'h7A; // z
	localparam logic [7:0] R_DUP_LST = 8'h5A; // Z
	localparam logic [7:0] R_DOUBLE  = 8'h71; // q
	localparam logic [7:0] R_REPEAT  = 8'h70; // p

	// Source of each scratch byte in a rebuilding walk.
	typedef enum logic [1:0] {
		SRC_WORD,
		SRC_ARG,
		SRC_SKIP,
		SRC_DONE
	} src_kind_t;

	typedef struct packed {
		src_kind_t kind;
		logic      from_arg_b;
	} src_sel_t;

	function automatic logic [3:0] digit_of(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = c - CH_ZERO;
			digit_of = (c >= CH_ZERO && c <= CH_NINE) ? d[3:0] : 4'd0;
		end
	endfunction

	function automatic logic is_upper(input logic [7:0] b);
		is_upper = (b >= CH_UP_A && b <= CH_UP_Z);
	endfunction

	function automatic logic is_lower(input logic [7:0] b);
		is_lower = (b >= CH_LOW_A && b <= CH_LOW_Z);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		to_lower = is_upper(b) ? (b + CASE_BIT) : b;
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] b);
		to_upper = is_lower(b) ? (b - CASE_BIT) : b;
	endfunction

	function automatic logic [7:0] toggle(input logic [7:0] b);
		toggle = is_lower(b) ? (b - CASE_BIT) : (is_upper(b) ? (b + CASE_BIT) : b);
	endfunction

	function automatic logic is_rebuild(input logic [7:0] c);
		is_rebuild = (c == R_REVERSE) || (c == R_DUP) || (c == R_MIRROR) ||
			(c == R_ROT_L) || (c == R_ROT_R) || (c == R_APPEND) || (c == R_PREPEND) ||
			(c == R_DEL_FST) || (c == R_DEL_AT) || (c == R_EXTRACT) ||
			(c == R_INSERT) || (c == R_PURGE) || (c == R_DUP_FST) ||
			(c == R_DUP_LST) || (c == R_DOUBLE) || (c == R_REPEAT);
	endfunction

	function automatic logic is_inplace(input logic [7:0] c);
		is_inplace = (c == R_LOWER) || (c == R_UPPER) || (c == R_TOGGLE) ||
			(c == R_SUBST);
	endfunction

endpackage

// ===== hw/rtl/wmre_walker.sv =====
// Walk step generator: gives the source of each scratch byte for a rebuild.
module wmre_walker import wmre_pkg::*; #(
	parameter int LW = 6,
	parameter int SW = 10
) (
	input  logic [7:0]    cmd,
	input  logic [LW-1:0] len,
	input  logic [3:0]    n,
	input  logic [3:0]    m,
	input  logic [SW-1:0] step,
	input  logic [LW-1:0] rep,
	output src_sel_t      sel,
	output logic [LW-1:0] rd_idx
);
	// step: current walk step; the source index is derived per command.
	// rep: step index wrapped at the word length, kept by the sequencer.
	logic [SW-1:0] len_w, n_w, m_w, last_w, tot, j;
	always_comb begin
		len_w  = SW'(len);
		n_w    = SW'(n);
		m_w    = SW'(m);
		last_w = len_w - SW'(1);
		sel.kind = SRC_DONE;
		sel.from_arg_b = 1'b0;
		j = step;
		tot = len_w;
		unique case (cmd)
			R_REVERSE: begin
				tot = len_w; j = last_w - step; sel.kind = SRC_WORD;
			end
			R_DUP: begin
				tot = len_w << 1; j = (step < len_w) ? step : step - len_w;
				sel.kind = SRC_WORD;
			end
			R_MIRROR: begin
				tot = len_w << 1;
				j = (step < len_w) ? step : (last_w - (step - len_w));
				sel.kind = SRC_WORD;
			end
			R_ROT_L: begin
				tot = len_w; j = (step == last_w) ? SW'(0) : step + SW'(1);
				sel.kind = SRC_WORD;
			end
			R_ROT_R: begin
				tot = len_w; j = (step == SW'(0)) ? last_w : step - SW'(1);
				sel.kind = SRC_WORD;
			end
			R_APPEND: begin
				tot = len_w + SW'(1);
				sel.kind = (step == len_w) ? SRC_ARG : SRC_WORD;
			end
			R_PREPEND: begin
				tot = len_w + SW'(1); j = step - SW'(1);
				sel.kind = (step == SW'(0)) ? SRC_ARG : SRC_WORD;
			end
			R_DEL_FST: begin
				tot = len_w; j = step;
				sel.kind = (step == SW'(0)) ? SRC_SKIP : SRC_WORD;
			end
			R_DEL_AT: begin
				tot = len_w; sel.kind = (step == n_w) ? SRC_SKIP : SRC_WORD;
			end
			R_EXTRACT: begin
				// a range past the end leaves the word as it is
				tot = len_w;
				sel.kind = (n_w + m_w <= len_w && step >= n_w && step < n_w + m_w) ?
					SRC_SKIP : SRC_WORD;
			end
			R_INSERT: begin
				// a position past the end leaves the word as it is
				tot = (n_w > len_w) ? len_w : len_w + SW'(1); sel.from_arg_b = 1'b1;
				j = (step > n_w) ? step - SW'(1) : step;
				sel.kind = (step == n_w) ? SRC_ARG : SRC_WORD;
			end
			R_PURGE: begin
				tot = len_w; sel.kind = SRC_WORD; // compare done by caller
			end
			R_DUP_FST: begin
				tot = len_w + n_w;
				j = (step < n_w) ? SW'(0) : step - n_w; sel.kind = SRC_WORD;
			end
			R_DUP_LST: begin
				tot = len_w + n_w;
				j = (step < len_w) ? step : last_w; sel.kind = SRC_WORD;
			end
			R_DOUBLE: begin
				tot = len_w << 1; j = step >> 1; sel.kind = SRC_WORD;
			end
			R_REPEAT: begin
				tot = len_w * n_w; sel.kind = SRC_WORD;
				j = SW'(rep);
			end
			default: begin
				tot = SW'(0);
			end
		endcase
		if (step >= tot) sel.kind = SRC_DONE;
		rd_idx = j[LW-1:0];
	end
endmodule

// ===== hw/rtl/word_mangling_rule_engine_top.sv =====
// Top level: word mangling rule engine with sequencer, word and scratch memories.
//
// Usage: drive op, data_byte, rule_char, arg_a and arg_b and raise start;
// a request is taken at the clock edge where start is high and busy is low.
// Clear, append, c, C, T, o, ' and ] (and unknown commands) finish at the
// accepting edge: busy stays low and the next request can go on the next edge.
// In-place rules (l u t s) hold busy while they rewrite the word one byte a cycle.
// Rebuilding rules (r d f { } $ ^ [ D x i @ z Z q p) walk their source steps
// into a scratch memory one byte a cycle, then copy the new word back one
// byte a cycle; p walks up to 9*len steps but never writes more than MAX_LEN
// bytes.
// Read out holds busy while it gives one result per byte on out_byte, last,
// overflow and empty_res, the first registered at the edge after the
// accepting edge, each for exactly one cycle marked by valid; an empty word
// gives one result with empty_res set. The receiver cannot stall the block.
// Reset clears length, overflow and the sequencer; memory contents are left
// undefined, which is safe since bytes at or above the length are never read.
module word_mangling_rule_engine_top import wmre_pkg::*; #(
	parameter int MAX_LEN = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] op,
	input  logic [7:0] data_byte,
	input  logic [7:0] rule_char,
	input  logic [7:0] arg_a,
	input  logic [7:0] arg_b,
	output logic       valid,
	output logic [7:0] out_byte,
	output logic       last,
	output logic       overflow,
	output logic       empty_res
);
	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int AW = $clog2(MAX_LEN);
	localparam int SW = $clog2(9 * MAX_LEN + 2);

	typedef enum logic [2:0] {
		S_IDLE, S_INPLACE, S_WALK, S_COPY, S_READ, S_READ_EMPTY
	} state_t;

	state_t        state_q;
	logic [LW-1:0] len_q, slen_q;
	logic          ovf_q, cut_q;
	logic [7:0]    cmd_q, a_q, b_q;
	logic [SW-1:0] step_q;
	logic [LW-1:0] idx_q;
	logic [LW-1:0] rep_q;

	logic [7:0] word_mem [MAX_LEN];
	logic [7:0] scr_mem  [MAX_LEN];

	logic [3:0] n_d, m_d;
	assign n_d = digit_of(a_q);
	assign m_d = digit_of(b_q);

	src_sel_t      sel;
	logic [LW-1:0] wk_idx;
	wmre_walker #(.LW(LW), .SW(SW)) u_walk (
		.cmd(cmd_q), .len(len_q), .n(n_d), .m(m_d), .step(step_q), .rep(rep_q),
		.sel(sel), .rd_idx(wk_idx)
	);

	// Combinational word read; in-place and walk paths address it by index.
	logic [7:0] wrd, srd;
	logic [LW-1:0] rd_addr;
	always_comb begin
		unique case (state_q)
			S_WALK:  rd_addr = wk_idx;
			default: rd_addr = idx_q;
		endcase
		wrd = word_mem[rd_addr[AW-1:0]];
		srd = scr_mem[idx_q[AW-1:0]];
	end

	logic          acc;
	logic [3:0]    na;
	logic [LW-1:0] na_w;
	assign acc  = start && !busy;
	assign na   = digit_of(arg_a);
	assign na_w = LW'(na);
	assign busy = (state_q != S_IDLE);

	logic [7:0] put_byte;
	logic       put_en;
	always_comb begin
		put_byte = wrd;
		if (sel.kind == SRC_ARG) put_byte = sel.from_arg_b ? b_q : a_q;
		put_en = (sel.kind == SRC_WORD || sel.kind == SRC_ARG);
		if (cmd_q == R_PURGE && wrd == a_q) put_en = 1'b0;
	end

	// Memories: one write port each, clocked.
	always_ff @(posedge clk) begin
		if (acc && op == OP_APPEND && len_q < LW'(MAX_LEN))
			word_mem[len_q[AW-1:0]] <= data_byte;
		if (acc && op == OP_RULE && len_q != '0) begin
			if (rule_char == R_CAP) word_mem[0] <= to_upper(word_mem[0]);
			if (rule_char == R_UNCAP) word_mem[0] <= to_lower(word_mem[0]);
			if (rule_char == R_TOG_AT && na_w < len_q)
				word_mem[na_w[AW-1:0]] <= toggle(word_mem[na_w[AW-1:0]]);
			if (rule_char == R_OVER && na_w < len_q)
				word_mem[na_w[AW-1:0]] <= arg_b;
		end
		if (state_q == S_INPLACE) begin
			unique case (cmd_q)
				R_LOWER:  word_mem[idx_q[AW-1:0]] <= to_lower(wrd);
				R_UPPER:  word_mem[idx_q[AW-1:0]] <= to_upper(wrd);
				R_TOGGLE: word_mem[idx_q[AW-1:0]] <= toggle(wrd);
				default:  word_mem[idx_q[AW-1:0]] <= (wrd == a_q) ? b_q : wrd;
			endcase
		end
		if (state_q == S_WALK && put_en && slen_q < LW'(MAX_LEN))
			scr_mem[slen_q[AW-1:0]] <= put_byte;
		if (state_q == S_COPY && idx_q < slen_q)
			word_mem[idx_q[AW-1:0]] <= srd;
	end

	// Sequencer: state and registered result outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			len_q     <= '0;
			ovf_q     <= 1'b0;
			valid     <= 1'b0;
			cut_q     <= 1'b0;
			slen_q    <= '0;
			step_q    <= '0;
			idx_q     <= '0;
			rep_q     <= '0;
			cmd_q     <= '0;
			a_q       <= '0;
			b_q       <= '0;
			out_byte  <= '0;
			last      <= 1'b0;
			overflow  <= 1'b0;
			empty_res <= 1'b0;
		end else begin
			valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						cmd_q <= rule_char; a_q <= arg_a; b_q <= arg_b;
						idx_q <= '0; step_q <= '0; slen_q <= '0; cut_q <= 1'b0;
						rep_q <= '0;
						unique case (op)
							OP_CLEAR: begin
								len_q <= '0; ovf_q <= 1'b0;
							end
							OP_APPEND: begin
								if (len_q < LW'(MAX_LEN)) len_q <= len_q + LW'(1);
								else ovf_q <= 1'b1;
							end
							OP_RULE: begin
								if (len_q != '0) begin
									if (rule_char == R_TRUNC && na_w <= len_q) len_q <= na_w;
									if (rule_char == R_DEL_LST) len_q <= len_q - LW'(1);
									if (is_inplace(rule_char)) state_q <= S_INPLACE;
									if (is_rebuild(rule_char)) state_q <= S_WALK;
								end
							end
							default: begin
								state_q <= (len_q == '0) ? S_READ_EMPTY : S_READ;
							end
						endcase
					end
				end
				S_INPLACE: begin
					// advance one byte a cycle
					if (idx_q + LW'(1) >= len_q) state_q <= S_IDLE;
					idx_q <= idx_q + LW'(1);
				end
				S_WALK: begin
					if (sel.kind == SRC_DONE) begin
						state_q <= S_COPY; idx_q <= '0;
					end else begin
						step_q <= step_q + SW'(1);
						rep_q  <= (rep_q + LW'(1) == len_q) ? '0 : rep_q + LW'(1);
						if (put_en) begin
							if (slen_q < LW'(MAX_LEN)) slen_q <= slen_q + LW'(1);
							else cut_q <= 1'b1;
						end
					end
				end
				S_COPY: begin
					if (idx_q >= slen_q) begin
						len_q <= slen_q;
						if (cut_q) ovf_q <= 1'b1;
						state_q <= S_IDLE;
					end
					idx_q <= idx_q + LW'(1);
				end
				S_READ: begin
					valid     <= 1'b1;
					out_byte  <= wrd;
					last      <= (idx_q + LW'(1) == len_q);
					overflow  <= ovf_q;
					empty_res <= 1'b0;
					idx_q     <= idx_q + LW'(1);
					if (idx_q + LW'(1) == len_q) state_q <= S_IDLE;
				end
				default: begin
					valid <= 1'b1; out_byte <= '0; last <= 1'b1;
					overflow <= ovf_q; empty_res <= 1'b1;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(MAX_LEN)) else $error("word length beyond capacity");
	a_busy_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !$past(busy)) |-> !valid)
		else $error("result without read out");
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && empty_res) |-> last) else $error("empty result not last");
	a_clear_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && op == OP_CLEAR) |=> (!ovf_q && len_q == '0))
		else $error("clear did not reset word");
endmodule
